FILE: rtl/cid_pkg.sv
// ---------------------------------------------------------------------------
// Chord identifier package
// Shared types, the chord shape constants and the rotation helper.
// ---------------------------------------------------------------------------
package cid_pkg;

    localparam int NOTE_COUNT  = 128;
    localparam int PC_WIDTH    = 12;
    localparam int SHAPE_COUNT = 16;
    localparam int SCORE_LEVELS = 4;

    typedef logic [PC_WIDTH-1:0] pcs_t;
    typedef logic [3:0]          pclass_t;
    typedef logic [1:0]          score_t;

    // Shapes rooted on class 0, bit k set for an interval of k semitones.
    localparam pcs_t SHAPES [SHAPE_COUNT] = '{
        12'h091,  // major
        12'h089,  // minor
        12'h085,  // sus2
        12'h0A1,  // sus4
        12'h049,  // diminished
        12'h111,  // augmented
        12'h291,  // sixth
        12'h491,  // dominant seventh
        12'h891,  // major seventh
        12'h489,  // minor seventh
        12'h449,  // half-diminished seventh
        12'h249,  // diminished seventh
        12'h895,  // major ninth
        12'h495,  // dominant ninth
        12'h48D,  // minor ninth
        12'h8B5   // major eleventh
    };

    // Classified beat handed from the front end to the matcher.
    typedef struct packed {
        pcs_t    pcs;
        logic    held;
        pclass_t bass;
    } class_t;

    // Rotate a pitch-class set upwards by a number of semitones (0 to 11).
    function automatic pcs_t rot12(input pcs_t v, input int by);
        logic [2*PC_WIDTH-1:0] dd;
        dd = {v, v};
        return PC_WIDTH'(dd >> (PC_WIDTH - by));
    endfunction

endpackage

FILE: rtl/cid_front.sv
// ---------------------------------------------------------------------------
// Chord identifier front end
// Accepts note masks, folds them into a pitch-class set and finds the bass.
// ---------------------------------------------------------------------------
module cid_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cid_pkg::NOTE_COUNT-1:0]     notes,
    output logic                               out_valid,
    input  logic                               out_ready,
    output cid_pkg::class_t                    out_item
);

    logic                           vld_reg;
    logic                           vld_next;
    cid_pkg::class_t                item_reg;
    cid_pkg::class_t                item_next;
    logic [cid_pkg::NOTE_COUNT-1:0] lowest;
    cid_pkg::pcs_t                  bass_onehot;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    // Isolating the lowest held note lets the bass be folded like the set itself.
    assign lowest = notes & (~notes + 1'b1);

    always_comb
    begin
        item_next.pcs  = '0;
        item_next.bass = '0;
        bass_onehot    = '0;
        for (int n = 0; n < cid_pkg::NOTE_COUNT; n++)
        begin
            item_next.pcs[n % cid_pkg::PC_WIDTH] =
                item_next.pcs[n % cid_pkg::PC_WIDTH] | notes[n];
            bass_onehot[n % cid_pkg::PC_WIDTH] =
                bass_onehot[n % cid_pkg::PC_WIDTH] | lowest[n];
        end
        for (int k = 0; k < cid_pkg::PC_WIDTH; k++)
        begin
            if (bass_onehot[k])
            begin
                item_next.bass = item_next.bass | 4'(k);
            end
        end
        item_next.held = |notes;
        vld_next = in_ready ? in_valid : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: rtl/cid_queue.sv
// ---------------------------------------------------------------------------
// Chord identifier queue
// Two-entry queue between the front end and the matcher.
// ---------------------------------------------------------------------------
module cid_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cid_pkg::class_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output cid_pkg::class_t out_item
);

    cid_pkg::class_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/cid_back.sv
// ---------------------------------------------------------------------------
// Chord identifier matcher
// Compares the set with every rotated shape, scores the hits and picks one.
// ---------------------------------------------------------------------------
module cid_back #(
    parameter int NUM_TRIED = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cid_pkg::pclass_t tonic,
    input  logic             in_valid,
    output logic             in_ready,
    input  cid_pkg::class_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      out_data
);

    localparam int LV = cid_pkg::SCORE_LEVELS;

    // Match stage: per shape, which score levels were hit and the first root for each.
    logic                                a_vld_reg;
    logic                                a_vld_next;
    cid_pkg::class_t                     a_item_reg;
    logic [LV-1:0]                       a_hit_reg  [NUM_TRIED];
    logic [LV-1:0]                       a_hit_next [NUM_TRIED];
    logic [LV-1:0][3:0]                  a_root_reg  [NUM_TRIED];
    logic [LV-1:0][3:0]                  a_root_next [NUM_TRIED];

    // Output register.
    logic        o_vld_reg;
    logic        o_vld_next;
    logic [31:0] o_data_reg;
    logic [31:0] o_data_next;

    logic a_ready;
    logic o_ready;

    assign o_ready   = !o_vld_reg || out_ready;
    assign a_ready   = !a_vld_reg || o_ready;
    assign in_ready  = a_ready;
    assign out_valid = o_vld_reg;
    assign out_data  = o_data_reg;

    always_comb
    begin
        cid_pkg::score_t sc;
        sc = '0;
        for (int s = 0; s < NUM_TRIED; s++)
        begin
            a_hit_next[s]  = '0;
            a_root_next[s] = '0;
            // Walking roots downwards leaves the lowest matching root in each level.
            for (int r = cid_pkg::PC_WIDTH - 1; r >= 0; r--)
            begin
                if (in_item.pcs == cid_pkg::rot12(cid_pkg::SHAPES[s], r))
                begin
                    sc = {in_item.held && (4'(r) == in_item.bass), 4'(r) == tonic};
                    a_hit_next[s][sc]  = 1'b1;
                    a_root_next[s][sc] = 4'(r);
                end
            end
        end
        a_vld_next = a_ready ? in_valid : a_vld_reg;
    end

    always_comb
    begin
        logic [LV-1:0]    any_lvl;
        cid_pkg::score_t  best;
        logic             found;
        cid_pkg::pclass_t root;
        logic [3:0]       shape;
        logic             slash;
        any_lvl = '0;
        best    = '0;
        root    = '0;
        shape   = '0;
        for (int s = 0; s < NUM_TRIED; s++)
        begin
            any_lvl = any_lvl | a_hit_reg[s];
        end
        found = |any_lvl;
        priority if (any_lvl[3])
        begin
            best = 2'd3;
        end
        else if (any_lvl[2])
        begin
            best = 2'd2;
        end
        else if (any_lvl[1])
        begin
            best = 2'd1;
        end
        else
        begin
            best = 2'd0;
        end
        // Earliest shape in the best level wins.
        for (int s = NUM_TRIED - 1; s >= 0; s--)
        begin
            if (a_hit_reg[s][best])
            begin
                shape = 4'(s);
                root  = a_root_reg[s][best];
            end
        end
        slash = found && (root != a_item_reg.bass);
        o_data_next = {1'b0,
                       a_item_reg.held ? a_item_reg.bass : 4'd0,
                       a_item_reg.held,
                       a_item_reg.pcs,
                       slash ? a_item_reg.bass : 4'd0,
                       slash,
                       found ? shape : 4'd0,
                       found ? root : 4'd0,
                       found};
        o_vld_next = o_ready ? a_vld_reg : o_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            o_vld_reg <= o_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_item_reg <= in_item;
            a_hit_reg  <= a_hit_next;
            a_root_reg <= a_root_next;
        end
        if (o_ready && a_vld_reg)
        begin
            o_data_reg <= o_data_next;
        end
    end

endmodule

FILE: rtl/chord_identifier.sv
// ---------------------------------------------------------------------------
// Chord identifier
// Names the chord formed by a mask of held MIDI notes.
// ---------------------------------------------------------------------------
// Each slave beat carries a 128-bit held-note mask; each master beat carries
// one result: whether a chord shape matched the folded pitch-class set, its
// root and shape, a slash bass, the set itself and the bass class.
// The tonic register is written through cfg_we/cfg_wdata and gives a bonus
// to chords rooted on that class. The user must write it only while the
// block is idle; the block itself does not enforce this. A beat is accepted
// into the front register, which folds the mask and finds the bass; it
// passes a two-entry queue, then the match stage (one compare per shape and
// root) and the output register. One beat per cycle is sustained while the
// receiver keeps m_axis_tready high.
// When the receiver stalls, the output register holds its beat, the match
// stage and queue fill, and s_axis_tready falls once the front register is
// also full; nothing is lost. Reset empties every stage and sets the tonic
// to class 0.
// ---------------------------------------------------------------------------
module chord_identifier #(
    parameter int NUM_SHAPES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // notes_low[63:0], notes_high[127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // found[0], chord_root[4:1], shape_index[8:5],
                                         // has_slash[9], slash_note[13:10],
                                         // pitch_class_set[25:14], any_held[26],
                                         // bass_class[30:27], zero[31]
    input  logic         cfg_we,
    input  logic [3:0]   cfg_wdata
);

    localparam int NUM_TRIED = (NUM_SHAPES < cid_pkg::SHAPE_COUNT) ?
                               NUM_SHAPES : cid_pkg::SHAPE_COUNT;

    cid_pkg::pclass_t tonic_reg;
    cid_pkg::pclass_t tonic_next;
    logic             f_valid;
    logic             f_ready;
    cid_pkg::class_t  f_item;
    logic             q_valid;
    logic             q_ready;
    cid_pkg::class_t  q_item;

    always_comb
    begin
        tonic_next = cfg_we ? cfg_wdata : tonic_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tonic_reg <= '0;
        end
        else
        begin
            tonic_reg <= tonic_next;
        end
    end

    cid_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .notes     (s_axis_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    cid_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    cid_back #(
        .NUM_TRIED (NUM_TRIED)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tonic     (tonic_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
